### rtl/core/ihr_pkg.sv
package ihr_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EWMA_WEIGHT = 1'b1;

  // Field widths fixed by the interface
  localparam int DIST_W      = 33;
  localparam int CACHE_W     = 32;
  localparam int WEIGHT_W    = 17;
  localparam int RATIO_OUT_W = 17;
  localparam int CNT_OUT_W   = 32;

  // Q1.16 weight arithmetic
  localparam int EWMA_SHIFT = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  // Parameter defaults
  localparam int COUNT_WIDTH_DEF     = 32;
  localparam int RATIO_FRAC_BITS_DEF = 16;

endpackage

### rtl/core/interval_hit_ratio_ewma_unit.sv
// Interval LRU hit ratio with EWMA smoothing.
//
// Input channel (in_valid/in_ready): one request per transaction, carrying its
// reuse distance (-1 = cold miss) and an interval_end flag. A request hits when
// its distance is non-negative and below the configured capacity; else a miss.
// Output channel (out_valid/out_ready): one transaction per interval_end
// request, giving the smoothed Q1.F hit ratio and the closed interval's counts.
// Config port: cfg_we/cfg_index/cfg_wdata, index 0 = cache capacity,
// index 1 = ewma_weight (Q1.16, clamped to 1.0). Write only while idle.
//
// Requests that do not close an interval are taken back to back. A closing
// request keeps in_ready low while it runs through a close step, F restoring
// divider steps, a step to take the quotient, the two products on the shared
// multiplier plus a step to take the EWMA sum, and a hand-off step that loads
// the output register. The first interval skips the multiplier; no misses
// skips the divider (and the multiplier too on the first interval); a zero
// capacity skips both.
// Output is registered; the next request is taken while a result waits.
// A stalled receiver holds the result; a later close waits for the slot.
// Reset (rst_n, synchronous) clears counters, smoothing state and config.
module interval_hit_ratio_ewma_unit #(
  parameter int COUNT_WIDTH     = ihr_pkg::COUNT_WIDTH_DEF,
  parameter int RATIO_FRAC_BITS = ihr_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [ihr_pkg::DIST_W-1:0] in_reuse_distance,
  input  logic                              in_interval_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ihr_pkg::RATIO_OUT_W-1:0]   out_hit_ratio,
  output logic [ihr_pkg::CNT_OUT_W-1:0]     out_interval_hits,
  output logic [ihr_pkg::CNT_OUT_W-1:0]     out_interval_misses,
  input  logic                              cfg_we,
  input  logic [ihr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ihr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import ihr_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int F  = RATIO_FRAC_BITS;
  localparam int RW = F + 1;
  localparam logic [63:0] CNT_OUT_MAX   = 64'hFFFF_FFFF;
  localparam logic [31:0] RATIO_OUT_MAX = 32'h0001_FFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_DIV,
    ST_MAC,
    ST_HOLD
  } state_t;

  state_t state_r;

  logic [CACHE_W-1:0]  capacity_r;
  logic [WEIGHT_W-1:0] ewma_weight_r;
  logic [WEIGHT_W-1:0] weight_eff;

  logic [CW-1:0] hit_cnt_r;
  logic [CW-1:0] miss_cnt_r;
  logic [CW-1:0] snap_h_r;
  logic [CW-1:0] snap_m_r;
  logic [RW-1:0] ratio_r;
  logic [RW-1:0] smoothed_r;
  logic          first_r;

  logic          is_hit;
  logic [CW-1:0] hit_upd;
  logic [CW-1:0] miss_upd;
  logic          in_fire;
  logic          out_free;
  logic          out_load;

  logic          div_start;
  logic          div_done;
  logic [F-1:0]  div_q;
  logic          mac_start;
  logic          mac_done;
  logic [RW-1:0] mac_res;

  logic                   out_valid_r;
  logic [RATIO_OUT_W-1:0] out_ratio_r;
  logic [CNT_OUT_W-1:0]   out_hits_r;
  logic [CNT_OUT_W-1:0]   out_misses_r;
  logic [63:0]            h_wide;
  logic [63:0]            m_wide;
  logic [31:0]            r_wide;

  // hit test: sign bit clear and distance below capacity
  assign is_hit   = ~in_reuse_distance[DIST_W-1] &&
                    (in_reuse_distance[CACHE_W-1:0] < capacity_r);
  assign hit_upd  = (is_hit && !(&hit_cnt_r))   ? hit_cnt_r + 1'b1  : hit_cnt_r;
  assign miss_upd = (!is_hit && !(&miss_cnt_r)) ? miss_cnt_r + 1'b1 : miss_cnt_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == ST_HOLD) && out_free;

  assign weight_eff = (ewma_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : ewma_weight_r;

  // divider runs only when the interval saw at least one miss
  assign div_start = (state_r == ST_CLOSE) && (capacity_r != '0) && (snap_m_r != '0);
  assign mac_start = (state_r == ST_DIV) && div_done && !first_r;

  // output field saturation
  assign h_wide = 64'(snap_h_r);
  assign m_wide = 64'(snap_m_r);
  assign r_wide = 32'(ratio_r);

  ihr_div #(
    .CW (CW),
    .F  (F)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (snap_h_r),
    .divisor  ({1'b0, snap_h_r} + {1'b0, snap_m_r}),
    .done     (div_done),
    .quotient (div_q)
  );

  ihr_mac #(
    .RW (RW)
  ) u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mac_start || ((state_r == ST_CLOSE) && (capacity_r != '0) &&
                               (snap_m_r == '0) && !first_r)),
    .prev_ratio (smoothed_r),
    .new_ratio  (ratio_r),
    .weight     (weight_eff),
    .done       (mac_done),
    .result     (mac_res)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= '0;
      ewma_weight_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:    capacity_r    <= cfg_wdata[CACHE_W-1:0];
        CFG_EWMA_WEIGHT: ewma_weight_r <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      smoothed_r  <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_interval_end) begin
              snap_h_r   <= hit_upd;
              snap_m_r   <= miss_upd;
              hit_cnt_r  <= '0;
              miss_cnt_r <= '0;
              state_r    <= ST_CLOSE;
            end else begin
              hit_cnt_r  <= hit_upd;
              miss_cnt_r <= miss_upd;
            end
          end
        end
        ST_CLOSE: begin
          if (capacity_r == '0) begin
            // no capacity: ratio forced to zero, no smoothing
            ratio_r <= '0;
            state_r <= ST_HOLD;
          end else if (snap_m_r == '0) begin
            // no misses: zero with no hits, else exactly one
            ratio_r <= (snap_h_r == '0) ? '0 : (RW'(1) << F);
            state_r <= first_r ? ST_HOLD : ST_MAC;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ratio_r <= {1'b0, div_q};
            state_r <= first_r ? ST_HOLD : ST_MAC;
          end
        end
        ST_MAC: begin
          if (mac_done) begin
            ratio_r <= mac_res;
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            smoothed_r   <= ratio_r;
            first_r      <= 1'b0;
            out_ratio_r  <= (r_wide > RATIO_OUT_MAX) ? '1 : r_wide[RATIO_OUT_W-1:0];
            out_hits_r   <= (h_wide > CNT_OUT_MAX) ? '1 : h_wide[CNT_OUT_W-1:0];
            out_misses_r <= (m_wide > CNT_OUT_MAX) ? '1 : m_wide[CNT_OUT_W-1:0];
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit_ratio       = out_ratio_r;
  assign out_interval_hits   = out_hits_r;
  assign out_interval_misses = out_misses_r;

endmodule

### rtl/core/ihr_div.sv
module ihr_div #(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [CW-1:0] dividend,
  input  logic [CW:0]   divisor,
  output logic          done,
  output logic [F-1:0]  quotient
);

  localparam int CNT_W = $clog2(F + 1);

  logic [CW:0]    rem_r;
  logic [CW:0]    dvs_r;
  logic [F-1:0]   q_r;
  logic [CNT_W-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [CW+1:0]  shifted;
  logic [CW+2:0]  diff;
  logic           take;

  // one restoring step per cycle
  assign shifted = {rem_r, 1'b0};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign take    = ~diff[CW+2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(F);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
      dvs_r <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[CW:0] : shifted[CW:0];
      q_r   <= {q_r[F-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### rtl/core/ihr_mac.sv
module ihr_mac #(
  parameter int RW = 17
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [RW-1:0]                 prev_ratio,
  input  logic [RW-1:0]                 new_ratio,
  input  logic [ihr_pkg::WEIGHT_W-1:0]  weight,
  output logic                          done,
  output logic [RW-1:0]                 result
);

  import ihr_pkg::*;

  localparam int PW = RW + WEIGHT_W;
  localparam int AW = PW + 1;

  logic                phase_r;
  logic                done_r;
  logic [AW-1:0]       acc_r;
  logic [RW-1:0]       op_a;
  logic [WEIGHT_W-1:0] op_b;
  logic [PW-1:0]       prod;

  // shared multiplier: prev*w first, then new*(1-w)
  assign op_a = phase_r ? new_ratio : prev_ratio;
  assign op_b = phase_r ? (WEIGHT_ONE - weight) : weight;
  assign prod = PW'(op_a) * PW'(op_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= phase_r && !start;
      if (start) begin
        phase_r <= 1'b1;
      end else if (phase_r) begin
        phase_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {1'b0, prod};
    end else if (phase_r) begin
      acc_r <= acc_r + {1'b0, prod};
    end
  end

  assign done   = done_r;
  assign result = acc_r[EWMA_SHIFT +: RW];

endmodule

### tb/sv/tb_interval_hit_ratio_ewma_unit.sv
module tb_interval_hit_ratio_ewma_unit;
  import ihr_pkg::*;

  // Run controls
  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 40;    // margin after the last expected result
  localparam int HOLD_CYCLES   = 300;   // long receiver stall in the pressure test
  localparam int STALL_LIMIT   = 4000;  // cycles without any transaction
  localparam int MAX_REPORTS   = 10;

  // One interval result as the block reports it
  typedef struct packed {
    logic [RATIO_OUT_W-1:0] hit_ratio;
    logic [CNT_OUT_W-1:0]   hits;
    logic [CNT_OUT_W-1:0]   misses;
  } interval_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [DIST_W-1:0]   in_reuse_distance;
  logic                       in_interval_end;
  logic                       out_valid;
  logic                       out_ready;
  logic [RATIO_OUT_W-1:0]     out_hit_ratio;
  logic [CNT_OUT_W-1:0]       out_interval_hits;
  logic [CNT_OUT_W-1:0]       out_interval_misses;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  interval_hit_ratio_ewma_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_reuse_distance   (in_reuse_distance),
    .in_interval_end     (in_interval_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_hit_ratio       (out_hit_ratio),
    .out_interval_hits   (out_interval_hits),
    .out_interval_misses (out_interval_misses),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the block's state and registers, at reset values
  logic [CNT_OUT_W-1:0]   hit_cnt    = '0;
  logic [CNT_OUT_W-1:0]   miss_cnt   = '0;
  logic [RATIO_OUT_W-1:0] smooth     = '0;
  logic                   first_ivl  = 1'b1;
  logic [CACHE_W-1:0]     cfg_cache  = '0;
  logic [WEIGHT_W-1:0]    cfg_weight = '0;

  interval_result_t pending_intervals[$];

  int  fail_count    = 0;
  int  sent_count    = 0;
  int  checked_count = 0;
  int  config_count  = 0;

  // Idle controls shared by sender, receiver and the tests
  bit  tx_idle_en   = 1'b1;
  bit  rx_idle_en   = 1'b1;
  bit  rx_hold_req  = 1'b0;
  int  rx_hold_left = 0;
  int  rx_gap_left  = 0;

  // Classify one accepted request, update the counters and, on an interval
  // close, queue the smoothed ratio and the closed counts.
  function automatic void account_request(logic signed [DIST_W-1:0] distance, logic last);
    logic             is_hit;
    logic [63:0]      h;
    logic [63:0]      m;
    logic [63:0]      q;
    logic [63:0]      w;
    interval_result_t r;
    // any negative distance, cold miss or not, is a miss
    is_hit = !distance[DIST_W-1] && (distance[CACHE_W-1:0] < cfg_cache);
    if (is_hit) begin
      if (hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
    end else begin
      if (miss_cnt != '1) miss_cnt = miss_cnt + 1'b1;
    end
    if (!last) return;
    h = 64'(hit_cnt);
    m = 64'(miss_cnt);
    if (cfg_cache == '0) begin
      q = 64'd0;  // zero cache also wipes the smoothing history
    end else begin
      q = (h + m == 64'd0) ? 64'd0 : (h << RATIO_FRAC_BITS_DEF) / (h + m);
      if (!first_ivl) begin
        w = (cfg_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(cfg_weight);
        q = (64'(smooth) * w + (64'(WEIGHT_ONE) - w) * q) >> EWMA_SHIFT;
      end
    end
    smooth    = q[RATIO_OUT_W-1:0];
    first_ivl = 1'b0;
    r.hit_ratio = (q > 64'h1FFFF) ? '1 : q[RATIO_OUT_W-1:0];
    r.hits      = hit_cnt;
    r.misses    = miss_cnt;
    hit_cnt  = '0;
    miss_cnt = '0;
    pending_intervals.push_back(r);
  endfunction

  // Called at a rising edge. Valid is left high after acceptance, so a
  // back-to-back request never lowers and raises it in the same step.
  task automatic send_request(logic signed [DIST_W-1:0] distance, logic last);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_reuse_distance <= distance;
    in_interval_end   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    account_request(distance, last);
    sent_count++;
  endtask

  // Drop valid, wait out every expected result, then let the back part settle
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only while the block is idle
  task automatic write_config(logic [CFG_DATA_W-1:0] cache, logic [CFG_DATA_W-1:0] weight);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CAPACITY;
    cfg_wdata <= cache;
    @(posedge clk);
    cfg_cache = cache[CACHE_W-1:0];
    cfg_index <= CFG_EWMA_WEIGHT;
    cfg_wdata <= weight;
    @(posedge clk);
    cfg_weight = weight[WEIGHT_W-1:0];
    cfg_we <= 1'b0;
    config_count++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_cache();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'($urandom_range(2, 64));
      default: return 32'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'(WEIGHT_ONE);
      2:       return 32'h0001_FFFF;
      3:       return 32'($urandom_range(0, 65536));
      default: return 32'($urandom());  // upper bits beyond the register
    endcase
  endfunction

  // Mix of cold misses, other negatives, values around the cache boundary
  // and plain hits
  function automatic logic signed [DIST_W-1:0] pick_distance(logic [CACHE_W-1:0] cache);
    logic [DIST_W-1:0] near;
    case ($urandom_range(0, 9))
      0: return -33'sd1;
      1: return {1'b1, 32'($urandom())};
      2: return {1'b0, 32'($urandom())};
      3: return '0;
      4: return {1'b0, 32'hFFFF_FFFF};
      5, 6: begin
        near = {1'b0, cache} + 33'($urandom_range(0, 2)) - 33'd1;
        return {1'b0, near[CACHE_W-1:0]};
      end
      default: return (cache == '0) ? '0 : {1'b0, 32'($urandom_range(0, cache - 1))};
    endcase
  endfunction

  // Well-formed intervals with random content; now and then a long one
  task automatic send_intervals(int n_items, int max_len);
    int left;
    int len;
    int k;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4 * max_len)
                                        : $urandom_range(1, max_len);
      if (len > left) len = left;
      for (k = 0; k < len; k++) send_request(pick_distance(cfg_cache), k == len - 1);
      left -= len;
    end
  endtask

  task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s mismatch on result %0d: expected %0h, actual %0h",
               field, checked_count, want, got);
  endtask

  // ---------------------------------------------------------------- tests

  // Registers still at reset: capacity 0, so every request misses and the
  // ratio is 0.
  task automatic test_reset_config();
    send_request(33'sd0, 1'b0);
    send_request(-33'sd1, 1'b1);
  endtask

  // Distances on both sides of a small cache, cold and other negative
  // misses, then an all-miss and an all-hit interval (weight 0: no history).
  task automatic test_distance_edges();
    wait_for_results();
    write_config(32'd16, 32'd0);
    send_request(33'sd0, 1'b0);
    send_request(33'sd15, 1'b0);
    send_request(33'sd16, 1'b0);
    send_request(-33'sd1, 1'b0);
    send_request(-33'sd2, 1'b0);
    send_request({1'b1, 32'd0}, 1'b0);           // most negative
    send_request({1'b0, 32'hFFFF_FFFF}, 1'b1);   // largest distance
    send_request(-33'sd1, 1'b1);
    send_request(33'sd3, 1'b0);
    send_request(33'sd7, 1'b1);
  endtask

  // Full cache size; weight at one, above one (clamped) and with junk above
  // the register width.
  task automatic test_weight_extremes();
    wait_for_results();
    write_config(32'hFFFF_FFFF, 32'(WEIGHT_ONE));
    send_request({1'b0, 32'hFFFF_FFFE}, 1'b0);
    send_request({1'b0, 32'hFFFF_FFFF}, 1'b1);
    wait_for_results();
    write_config(32'hFFFF_FFFF, 32'h0001_FFFF);
    send_request(33'sd5, 1'b1);
    wait_for_results();
    write_config(32'hFFFF_FFFF, 32'h0001_0001);
    send_request(-33'sd1, 1'b1);
    wait_for_results();
    write_config(32'hFFFF_FFFF, 32'hFFFE_8000);
    send_request(33'sd1, 1'b0);
    send_request(33'sd2, 1'b0);
    send_request(-33'sd1, 1'b1);
  endtask

  // Zero cache mid-run clears the smoothed value; the next interval blends
  // from zero.
  task automatic test_zero_cache_clears();
    wait_for_results();
    write_config(32'd0, 32'h0000_4000);
    send_request(33'sd9, 1'b1);
    wait_for_results();
    write_config(32'd8, 32'h0000_4000);
    send_request(33'sd1, 1'b1);
  endtask

  // Random phases under varying settings; some phases end mid-interval so
  // partial counts carry across a register change.
  task automatic test_random_traffic();
    int                    phase;
    logic [CFG_DATA_W-1:0] cache;
    logic [CFG_DATA_W-1:0] weight;
    for (phase = 0; phase < 8; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          cache  = 32'd1;
          weight = 32'd0;
        end
        1: begin
          cache  = 32'hFFFF_FFFF;
          weight = 32'(WEIGHT_ONE);
        end
        default: begin
          cache  = pick_cache();
          weight = pick_weight();
        end
      endcase
      write_config(cache, weight);
      send_intervals(165, 24);
      repeat ($urandom_range(0, 3)) send_request(pick_distance(cfg_cache), 1'b0);
    end
  endtask

  // Receiver stalls for a long stretch while short intervals keep coming,
  // so results back up and the input stalls.
  task automatic test_backpressure();
    wait_for_results();
    write_config(32'd40, 32'h0000_C000);
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    send_intervals(80, 3);
    tx_idle_en  = 1'b1;
  endtask

  // Last part: no idling on either side
  task automatic test_steady_stream();
    wait_for_results();
    write_config(pick_cache(), pick_weight());
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_intervals(260, 24);
  endtask

  // ---------------------------------------------------------------- processes

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin : drive_out_ready
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_left = HOLD_CYCLES;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_gap_left > 0) begin
        out_ready <= 1'b0;
        rx_gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 5) == 0) rx_gap_left = $urandom_range(1, 11);
      end
    end
  end

  // Every result transaction against the oldest expected interval
  always @(posedge clk) begin : check_results
    interval_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_intervals.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: ratio %0h hits %0d misses %0d",
                   out_hit_ratio, out_interval_hits, out_interval_misses);
      end else begin
        want = pending_intervals.pop_front();
        if (out_hit_ratio !== want.hit_ratio)
          note_mismatch("hit_ratio", 32'(want.hit_ratio), 32'(out_hit_ratio));
        if (out_interval_hits !== want.hits)
          note_mismatch("interval_hits", want.hits, out_interval_hits);
        if (out_interval_misses !== want.misses)
          note_mismatch("interval_misses", want.misses, out_interval_misses);
        checked_count++;
      end
    end
  end

  // Watchdog: too long without a transaction on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_interval_hit_ratio_ewma_unit: errors");
    $finish;
  end

  initial begin : run_tests
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_reuse_distance <= '0;
    in_interval_end   <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_CAPACITY;
    cfg_wdata         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_distance_edges();
    test_weight_extremes();
    test_zero_cache_clears();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();
    wait_for_results();

    $display("run: %0d requests, %0d interval results checked, %0d register settings",
             sent_count, checked_count, config_count);
    $display("run: zero and full cache sizes, weight clamp, carry-over and a long output stall");
    if (fail_count == 0 && pending_intervals.size() == 0) begin
      $display("tb_interval_hit_ratio_ewma_unit: clean");
    end else begin
      $display("tb_interval_hit_ratio_ewma_unit: errors");
    end
    $finish;
  end

endmodule

### interval_hit_ratio_ewma_unit.f
rtl/core/ihr_pkg.sv
rtl/core/ihr_div.sv
rtl/core/ihr_mac.sv
rtl/core/interval_hit_ratio_ewma_unit.sv
tb/sv/tb_interval_hit_ratio_ewma_unit.sv
